// ===== hdl/pts_pkg.sv =====
`timescale 1ns / 1ps

package pts_pkg;

    typedef enum logic [2:0] {
        CMD_CREATE = 3'd0,
        CMD_DELAY  = 3'd1,
        CMD_TICK   = 3'd2,
        CMD_PEND   = 3'd3,
        CMD_POST   = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_ACQUIRED = 2'd1,
        ST_BLOCKED  = 2'd2,
        ST_REJECTED = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        TS_EMPTY   = 2'd0,
        TS_READY   = 2'd1,
        TS_WAITING = 2'd2
    } task_state_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_TICK,
        FSM_PICK,
        FSM_OUT
    } fsm_t;

    localparam logic [15:0] FOREVER_TICKS = 16'hFFFF;

endpackage

// ===== hdl/priority_task_scheduler_mutex.sv =====
`timescale 1ns / 1ps
// Sequence: create, delay, pend and post run a selection scan over all slots, one slot per
// cycle through one shared priority comparator, and then raise m_valid; a tick first runs a
// tick pass over slots 1 to TASK_SLOTS - 1 and then the selection scan.
// Throughput: one item at a time; s_ready is low until the result is taken.
// Reset (aresetn, synchronous, active low): slot 0 ready idle task, all other slots empty,
// all mutexes free, no inheritance, current task 0.
module priority_task_scheduler_mutex #(
    parameter int TASK_SLOTS  = 8,
    parameter int MUTEX_COUNT = 4,
    parameter int IDLE_LEVEL  = 255
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_command,
    input  logic [2:0] s_task_index,
    input  logic [7:0] s_priority_req,
    input  logic [15:0] s_delay_ticks,
    input  logic [1:0] s_mutex_index,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_status,
    output logic [2:0] m_next_task,
    output logic       m_switch_flag
);

    localparam int TW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int MW = (MUTEX_COUNT > 1) ? $clog2(MUTEX_COUNT) : 1;
    localparam int PW = (IDLE_LEVEL > 255) ? $clog2(IDLE_LEVEL + 1) : 8;
    localparam logic [PW-1:0] IDLE_P = PW'(IDLE_LEVEL);

    pts_pkg::task_state_t tstat_reg [TASK_SLOTS];
    logic [PW-1:0] base_reg [TASK_SLOTS];
    logic [PW-1:0] inh_reg  [TASK_SLOTS];
    logic [15:0]   dly_reg  [TASK_SLOTS];
    logic          wv_reg   [TASK_SLOTS];
    logic [MW-1:0] wm_reg   [TASK_SLOTS];
    logic          mfree_reg [MUTEX_COUNT];
    logic [TW-1:0] mown_reg  [MUTEX_COUNT];
    logic [TW-1:0] cur_reg;

    pts_pkg::fsm_t state_reg, state_next;
    logic [TW:0]   scan_reg;
    logic [TW-1:0] best_reg;
    logic [PW-1:0] bestp_reg;
    logic [1:0]    status_reg;
    logic [2:0]    next_task_reg;
    logic          switch_reg;

    logic [TW-1:0] si;
    logic [PW-1:0] sp;
    assign si = scan_reg[TW-1:0];
    assign sp = (base_reg[si] < inh_reg[si]) ? base_reg[si] : inh_reg[si];

    // command decode on accept
    logic          acc;
    logic          idx_ok, mtx_ok;
    logic [TW-1:0] idx, mi_t;
    logic [MW-1:0] mi;
    logic [PW-1:0] cur_p;
    assign acc = s_valid && s_ready;
    assign idx_ok = (32'(s_task_index) < TASK_SLOTS) && (s_task_index != 3'd0);
    assign idx = TW'(s_task_index);
    assign mtx_ok = 32'(s_mutex_index) < MUTEX_COUNT;
    assign mi = MW'(s_mutex_index);
    assign mi_t = mown_reg[mi];
    assign cur_p = (base_reg[cur_reg] < inh_reg[cur_reg]) ? base_reg[cur_reg]
                                                           : inh_reg[cur_reg];

    assign s_ready = (state_reg == pts_pkg::FSM_IDLE);
    assign m_valid = (state_reg == pts_pkg::FSM_OUT);
    assign m_status = status_reg;
    assign m_next_task = next_task_reg;
    assign m_switch_flag = switch_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pts_pkg::FSM_IDLE: begin
                if (acc) begin
                    state_next = (s_command == pts_pkg::CMD_TICK) ? pts_pkg::FSM_TICK
                                                                   : pts_pkg::FSM_PICK;
                end
            end
            pts_pkg::FSM_TICK: begin
                if (32'(scan_reg) == TASK_SLOTS - 1) state_next = pts_pkg::FSM_PICK;
            end
            pts_pkg::FSM_PICK: begin
                if (32'(scan_reg) == TASK_SLOTS - 1) state_next = pts_pkg::FSM_OUT;
            end
            pts_pkg::FSM_OUT: begin
                if (m_ready) state_next = pts_pkg::FSM_IDLE;
            end
            default: state_next = pts_pkg::FSM_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pts_pkg::FSM_IDLE;
            cur_reg   <= '0;
            scan_reg  <= '0;
            for (int s = 0; s < TASK_SLOTS; s++) begin
                tstat_reg[s] <= (s == 0) ? pts_pkg::TS_READY : pts_pkg::TS_EMPTY;
                inh_reg[s]   <= IDLE_P;
                dly_reg[s]   <= '0;
                wv_reg[s]    <= 1'b0;
            end
            base_reg[0] <= IDLE_P;
            for (int m = 0; m < MUTEX_COUNT; m++) mfree_reg[m] <= 1'b1;
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                pts_pkg::FSM_IDLE: begin
                    if (acc) begin
                        status_reg <= pts_pkg::ST_REJECTED;
                        scan_reg   <= (s_command == pts_pkg::CMD_TICK) ? (TW+1)'(1) : '0;
                        best_reg   <= '0;
                        bestp_reg  <= '1;
                        unique case (s_command)
                            pts_pkg::CMD_CREATE: begin
                                if (idx_ok && tstat_reg[idx] == pts_pkg::TS_EMPTY) begin
                                    tstat_reg[idx] <= pts_pkg::TS_READY;
                                    base_reg[idx]  <= PW'(s_priority_req);
                                    inh_reg[idx]   <= IDLE_P;
                                    dly_reg[idx]   <= '0;
                                    wv_reg[idx]    <= 1'b0;
                                    status_reg     <= pts_pkg::ST_DONE;
                                end
                            end
                            pts_pkg::CMD_DELAY: begin
                                if (cur_reg != '0) begin
                                    dly_reg[cur_reg]   <= s_delay_ticks;
                                    tstat_reg[cur_reg] <= pts_pkg::TS_WAITING;
                                    status_reg         <= pts_pkg::ST_BLOCKED;
                                end
                            end
                            pts_pkg::CMD_TICK: begin
                                status_reg <= pts_pkg::ST_DONE;
                            end
                            pts_pkg::CMD_PEND: begin
                                if (mtx_ok) begin
                                    if (mfree_reg[mi] || mi_t == cur_reg) begin
                                        mfree_reg[mi] <= 1'b0;
                                        mown_reg[mi]  <= cur_reg;
                                        status_reg    <= pts_pkg::ST_ACQUIRED;
                                    end else if (cur_reg != '0) begin
                                        if (cur_p < inh_reg[mi_t]) inh_reg[mi_t] <= cur_p;
                                        wv_reg[cur_reg]    <= 1'b1;
                                        wm_reg[cur_reg]    <= mi;
                                        dly_reg[cur_reg]   <= s_delay_ticks;
                                        tstat_reg[cur_reg] <= pts_pkg::TS_WAITING;
                                        status_reg         <= pts_pkg::ST_BLOCKED;
                                    end
                                end
                            end
                            pts_pkg::CMD_POST: begin
                                if (mtx_ok && !mfree_reg[mi] && mi_t == cur_reg) begin
                                    mfree_reg[mi]    <= 1'b1;
                                    inh_reg[cur_reg] <= IDLE_P;
                                    status_reg       <= pts_pkg::ST_DONE;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                pts_pkg::FSM_TICK: begin
                    if (tstat_reg[si] == pts_pkg::TS_WAITING) begin
                        if (wv_reg[si] && mfree_reg[wm_reg[si]]) begin
                            mfree_reg[wm_reg[si]] <= 1'b0;
                            mown_reg[wm_reg[si]]  <= si;
                            wv_reg[si]    <= 1'b0;
                            dly_reg[si]   <= '0;
                            tstat_reg[si] <= pts_pkg::TS_READY;
                        end else if (dly_reg[si] == 16'd1 || dly_reg[si] == 16'd0) begin
                            dly_reg[si]   <= '0;
                            wv_reg[si]    <= 1'b0;
                            tstat_reg[si] <= pts_pkg::TS_READY;
                        end else if (dly_reg[si] != pts_pkg::FOREVER_TICKS) begin
                            dly_reg[si] <= dly_reg[si] - 16'd1;
                        end
                    end
                    scan_reg <= (32'(scan_reg) == TASK_SLOTS - 1) ? '0 : scan_reg + 1'b1;
                end
                pts_pkg::FSM_PICK: begin
                    logic [TW-1:0] nb;
                    nb = best_reg;
                    if (tstat_reg[si] == pts_pkg::TS_READY && sp < bestp_reg) begin
                        nb = si;
                        bestp_reg <= sp;
                    end
                    best_reg <= nb;
                    scan_reg <= scan_reg + 1'b1;
                    if (32'(scan_reg) == TASK_SLOTS - 1) begin
                        next_task_reg <= 3'(nb);
                        switch_reg    <= (nb != cur_reg);
                        cur_reg       <= nb;
                    end
                end
                pts_pkg::FSM_OUT: ;
                default: ;
            endcase
        end
    end

    a_idle_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        tstat_reg[0] == pts_pkg::TS_READY) else $error("idle slot not ready");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_next_task)) else $error("result lost");
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("ready while result pending");
    a_cur: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> 3'(cur_reg) == m_next_task) else $error("current task mismatch");

endmodule
